/* hdl/sfb_pkg.sv */
// Types and constants shared by the frame builder modules.
// No dependencies.
package sfb_pkg;

  // One input word: nine signed sensor readings.
  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
  } sensor_item_t;

  // One output word: a frame byte and its end-of-frame flag.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_word_t;

  // Header settings handed from the register block to the serialiser.
  typedef struct packed {
    logic [7:0] target_address;
    logic [7:0] frame_id;
  } hdr_cfg_t;

  localparam int unsigned FRAME_LEN = 24;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned HDR_LEN   = 4;

  localparam logic [IDX_W-1:0] IDX_TARGET  = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_FRAMEID = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_LENGTH  = IDX_W'(3);
  localparam logic [IDX_W-1:0] IDX_PAYLOAD = IDX_W'(HDR_LEN);
  localparam logic [IDX_W-1:0] IDX_SUM     = IDX_W'(FRAME_LEN - 2);
  localparam logic [IDX_W-1:0] IDX_ACC     = IDX_W'(FRAME_LEN - 1);

  localparam logic [7:0] FRAME_HEADER = 8'hAA;
  localparam logic [7:0] PAYLOAD_LEN  = 8'd18;

  localparam logic [7:0] TARGET_RESET  = 8'hFF;
  localparam logic [7:0] FRAMEID_RESET = 8'hF1;

  // Register select, taken from paddr[2].
  localparam logic REG_TARGET_ADDRESS = 1'b0;
  localparam logic REG_FRAME_ID       = 1'b1;

endpackage

/* hdl/sfb_cfg_regs.sv */
// APB-style register block holding the two header bytes.
// Depends on sfb_pkg.
module sfb_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output sfb_pkg::hdr_cfg_t  cfg
);

  logic [7:0] target_address;
  logic [7:0] frame_id;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_address <= sfb_pkg::TARGET_RESET;
      frame_id       <= sfb_pkg::FRAMEID_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        sfb_pkg::REG_TARGET_ADDRESS: target_address <= pwdata[7:0];
        sfb_pkg::REG_FRAME_ID:       frame_id       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      sfb_pkg::REG_TARGET_ADDRESS: prdata = {24'd0, target_address};
      sfb_pkg::REG_FRAME_ID:       prdata = {24'd0, frame_id};
      default:                     prdata = 32'd0;
    endcase
  end

  assign cfg.target_address = target_address;
  assign cfg.frame_id       = frame_id;

endmodule

/* hdl/sfb_serialiser.sv */
// Frame serialiser: byte index, byte select, running check bytes, output register.
// Depends on sfb_pkg.
module sfb_serialiser (
  input  logic                   clk,
  input  logic                   rst,
  input  sfb_pkg::hdr_cfg_t      cfg,
  input  logic                   load_valid,
  output logic                   load_ready,
  input  sfb_pkg::sensor_item_t  load_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sfb_pkg::frame_word_t   out_data
);

  sfb_pkg::sensor_item_t      cur;
  logic                       busy;
  logic [sfb_pkg::IDX_W-1:0]  idx;
  logic [7:0]                 sum;
  logic [7:0]                 acc;
  logic [7:0]                 sum_next;
  logic [7:0]                 acc_next;
  logic [sfb_pkg::IDX_W-1:0]  off;
  logic [15:0]                reading;
  logic [7:0]                 cur_byte;
  logic                       adv;
  logic                       at_end;

  assign adv        = busy && (!out_valid || out_ready);
  assign at_end     = (idx == sfb_pkg::IDX_ACC);
  assign load_ready = !busy || (adv && at_end);

  // Which reading, and which half of it, the payload index points at.
  assign off = idx - sfb_pkg::IDX_PAYLOAD;

  always_comb begin
    unique case (off[sfb_pkg::IDX_W-1:1])
      4'd0:    reading = cur.accel_x;
      4'd1:    reading = cur.accel_y;
      4'd2:    reading = cur.accel_z;
      4'd3:    reading = cur.gyro_x;
      4'd4:    reading = cur.gyro_y;
      4'd5:    reading = cur.gyro_z;
      4'd6:    reading = cur.mag_x;
      4'd7:    reading = cur.mag_y;
      4'd8:    reading = cur.mag_z;
      default: reading = 16'd0;
    endcase
  end

  always_comb begin
    priority if (idx == sfb_pkg::IDX_TARGET)  cur_byte = cfg.target_address;
    else if (idx == sfb_pkg::IDX_FRAMEID)     cur_byte = cfg.frame_id;
    else if (idx == sfb_pkg::IDX_LENGTH)      cur_byte = sfb_pkg::PAYLOAD_LEN;
    else if (idx < sfb_pkg::IDX_PAYLOAD)      cur_byte = sfb_pkg::FRAME_HEADER;
    else if (idx < sfb_pkg::IDX_SUM)          cur_byte = off[0] ? reading[15:8] : reading[7:0];
    else if (idx == sfb_pkg::IDX_SUM)         cur_byte = sum;
    else                                      cur_byte = acc;
  end

  // Fletcher-style pair over the first 22 bytes.
  assign sum_next = sum + cur_byte;
  assign acc_next = acc + sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      sum       <= 8'd0;
      acc       <= 8'd0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // a new word loads on the same edge as the last byte of the old frame
      if (load_valid && load_ready) begin
        busy <= 1'b1;
        idx  <= '0;
        sum  <= 8'd0;
        acc  <= 8'd0;
      end else if (adv) begin
        if (at_end) begin
          busy <= 1'b0;
        end
        if (idx < sfb_pkg::IDX_SUM) begin
          sum <= sum_next;
          acc <= acc_next;
        end
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      cur <= load_item;
    end
    if (adv) begin
      out_data.frame_byte <= cur_byte;
      out_data.last_byte  <= at_end;
    end
  end

endmodule

/* hdl/sensor_frame_builder_dual_checksum_top.sv */
// Telemetry frame builder: nine readings in, one 24-byte frame out, one byte per word.
// The byte rate is set by the serialiser, which issues one frame byte per cycle through
// its output register unless out_ready stalls it; a one-word input buffer takes the next
// item while the current frame is still going out, so frames follow each other with no
// gap. An accepted word passes through the input buffer and the serialiser's item
// register (cur) before its first frame byte reaches the output register. Frame layout: 0xAA,
// target_address, frame_id, 18, the nine readings low byte first (accel, gyro, mag;
// x, y, z), then the modulo-256 byte sum and the modulo-256 sum of running sums;
// last_byte marks the final check byte. Header bytes are read from the registers
// (target_address at 0x0, frame_id at 0x4) as the frame goes out, so change them
// only while idle.
// Depends on sfb_pkg, sfb_cfg_regs and sfb_serialiser.
module sensor_frame_builder_dual_checksum_top (
  input  logic                   clk,
  input  logic                   rst,
  // input words
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sfb_pkg::sensor_item_t  in_data,
  // output words
  output logic                   out_valid,
  input  logic                   out_ready,
  output sfb_pkg::frame_word_t   out_data,
  // register port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  sfb_pkg::hdr_cfg_t     cfg;
  sfb_pkg::sensor_item_t pend;
  logic                  pend_valid;
  logic                  load_ready;

  sfb_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input buffer: one word waiting for the serialiser. Ready comes straight off
  // a flop, so no combinational path runs from out_ready to in_ready.
  assign in_ready = !pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      pend_valid <= 1'b1;
    end else if (pend_valid && load_ready) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pend <= in_data;
    end
  end

  sfb_serialiser u_ser (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .load_valid (pend_valid),
    .load_ready (load_ready),
    .load_item  (pend),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

/* hdl/sfb_checker.sv */
// Port-level checks on the frame builder, bound to the top level.
// Depends on sfb_pkg.
module sfb_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input sfb_pkg::frame_word_t  out_data
);

  logic [sfb_pkg::IDX_W-1:0] pos;
  logic                      out_acc;

  assign out_acc = out_valid && out_ready;

  // Byte position within the current frame, as seen on the output.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (out_acc) begin
      pos <= (pos == sfb_pkg::IDX_ACC) ? '0 : pos + 1'b1;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> (out_data.last_byte == (pos == sfb_pkg::IDX_ACC)))
    else $error("last_byte not on byte 24 of the frame");

  a_header: assert property (@(posedge clk) disable iff (rst)
    out_acc && pos == '0 |-> out_data.frame_byte == sfb_pkg::FRAME_HEADER)
    else $error("frame does not open with the header byte");

  a_length: assert property (@(posedge clk) disable iff (rst)
    out_acc && pos == sfb_pkg::IDX_LENGTH |-> out_data.frame_byte == sfb_pkg::PAYLOAD_LEN)
    else $error("length byte wrong");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not empty after reset");

endmodule

bind sensor_frame_builder_dual_checksum_top sfb_checker u_sfb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
